FILE: sv/vector_axis_angle_rotate_defines.svh
// Assertion macros shared by the checker of the axis-angle rotation block.
// No dependencies; included by the checker file only.
`ifndef VECTOR_AXIS_ANGLE_ROTATE_DEFINES_SVH
`define VECTOR_AXIS_ANGLE_ROTATE_DEFINES_SVH

// Implication checked on the same edge, disabled while reset is high.
`define VAAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("vaar check failed");

// Implication checked on the next edge, active during reset as well.
`define VAAR_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vaar check failed");

`endif

FILE: sv/vaar_pkg.sv
// Package of the axis-angle rotation block: formats, latencies, the
// arctangent table and the Q30 helper functions. No dependencies.
package vaar_pkg;

  // Word formats.
  localparam int COMP_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int CALC_W      = 34;

  // Angle units: 1/64 degree.
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  // Radian conversion: r * PI_Q30 / HALF_TURN, with HALF_TURN = 45 * 2^8.
  // PI_Q30 splits into an integer step per angle unit and a remainder term;
  // the remainder term is divided by 2^8 and then by 45 through a reciprocal.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int RAD_INT      = int'(PI_Q30 / 32'(HALF_TURN));
  localparam int RAD_FRAC     = int'(PI_Q30 % 32'(HALF_TURN));
  localparam int RAD_SHIFT    = 8;
  localparam int RAD_DIV      = 45;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP_45     = (1 << RECIP_SHIFT) / RAD_DIV + 1;
  localparam int RAD_STAGES   = 2;

  // CORDIC.
  localparam int TRIG_STEPS  = 16;
  localparam int CORDIC_GAIN = 652032874;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // Axis normalization.
  localparam int SQRT_STEPS = 30;
  localparam int UDIV_STEPS = 31;

  // Latencies in clock edges.
  localparam int TRIG_LAT  = 1 + RAD_STAGES + 1 + TRIG_STEPS + 1;
  localparam int UNIT_LAT  = 2 + SQRT_STEPS + 1 + UDIV_STEPS + 1;
  localparam int MAT_LAT   = 5;
  localparam int TRIG_PAD  = UNIT_LAT - TRIG_LAT;
  localparam int TOTAL_LAT = UNIT_LAT + MAT_LAT + 1;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [31:0]           q30_t;
  typedef logic signed [CALC_W-1:0]     calc_t;

  // Arctangent of 2^-i in Q30.
  function automatic calc_t atan_q30(input int i);
    calc_t r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Q30 product, rounded with ties toward plus infinity.
  function automatic calc_t mulq(input calc_t a, input calc_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return p[63:30];
  endfunction

  // Clamp to [-1, 1] in Q30.
  function automatic q30_t clamp_q30(input calc_t v);
    calc_t r;
    if (v > ONE_Q30) begin
      r = calc_t'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      r = -calc_t'(ONE_Q30);
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

FILE: sv/vaar_trig.sv
// Cosine and sine of the angle: turn reduction, radian conversion by a
// split multiply and a reciprocal for the divide by 45, then an unrolled
// CORDIC. Uses vaar_pkg.
module vaar_trig import vaar_pkg::*; (
  input  logic                          clk,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output q30_t                          cos_q,
  output q30_t                          sin_q
);

  // Reduction into [-90, 90] degrees with a negate flag.
  logic signed [17:0] r0, r1, r2, r3;
  logic               neg_a;
  always_comb begin
    r0 = 18'(angle);
    if (r0 >= 18'(FULL_TURN)) begin
      r1 = r0 - 18'(FULL_TURN);
    end else if (r0 <= -18'(FULL_TURN)) begin
      r1 = r0 + 18'(FULL_TURN);
    end else begin
      r1 = r0;
    end
    if (r1 >= 18'(HALF_TURN)) begin
      r2 = r1 - 18'(FULL_TURN);
    end else if (r1 < -18'(HALF_TURN)) begin
      r2 = r1 + 18'(FULL_TURN);
    end else begin
      r2 = r1;
    end
    neg_a = 1'b0;
    r3    = r2;
    if (r2 > 18'(QUARTER_TURN)) begin
      r3    = r2 - 18'(HALF_TURN);
      neg_a = 1'b1;
    end else if (r2 < -18'(QUARTER_TURN)) begin
      r3    = r2 + 18'(HALF_TURN);
      neg_a = 1'b1;
    end
  end

  logic [12:0] a_mag;
  logic        a_sign, a_neg;
  always_ff @(posedge clk) begin
    a_mag  <= r3[17] ? 13'(-r3) : 13'(r3);
    a_sign <= r3[17];
    a_neg  <= neg_a;
  end

  // Integer radian step per unit, and the remainder term plus half the divisor.
  logic [31:0] rad_int;
  logic [25:0] rad_rem;
  logic        b_sign, b_neg;
  always_ff @(posedge clk) begin
    rad_int <= 32'(a_mag) * 32'(RAD_INT);
    rad_rem <= 26'(a_mag) * 26'(RAD_FRAC) + 26'(QUARTER_TURN);
    b_sign  <= a_sign;
    b_neg   <= a_neg;
  end

  // Drop the power-of-two part, divide by 45 through the reciprocal, and add.
  logic [17:0] rem_hi;
  logic [36:0] rem_prod;
  assign rem_hi   = rad_rem[25:RAD_SHIFT];
  assign rem_prod = 37'(rem_hi) * 37'(RECIP_45);

  logic [31:0] z_abs;
  logic        z_sign, z_neg;
  always_ff @(posedge clk) begin
    z_abs  <= rad_int + 32'(rem_prod >> RECIP_SHIFT);
    z_sign <= b_sign;
    z_neg  <= b_neg;
  end

  // CORDIC in rotation mode.
  calc_t cx [TRIG_STEPS+1];
  calc_t cy [TRIG_STEPS+1];
  calc_t cz [TRIG_STEPS+1];
  logic  cn [TRIG_STEPS+1];

  calc_t z_mag;
  assign z_mag = calc_t'(z_abs);

  always_ff @(posedge clk) begin
    cx[0] <= calc_t'(CORDIC_GAIN);
    cy[0] <= '0;
    cz[0] <= z_sign ? -z_mag : z_mag;
    cn[0] <= z_neg;
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cordic
    calc_t xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (!cz[i][CALC_W-1]) begin
        cx[i+1] <= cx[i] - ys;
        cy[i+1] <= cy[i] + xs;
        cz[i+1] <= cz[i] - atan_q30(i);
      end else begin
        cx[i+1] <= cx[i] + ys;
        cy[i+1] <= cy[i] - xs;
        cz[i+1] <= cz[i] + atan_q30(i);
      end
      cn[i+1] <= cn[i];
    end
  end

  // Undo the half-turn move and clamp to unit range.
  always_ff @(posedge clk) begin
    cos_q <= clamp_q30(cn[TRIG_STEPS] ? -cx[TRIG_STEPS] : cx[TRIG_STEPS]);
    sin_q <= clamp_q30(cn[TRIG_STEPS] ? -cy[TRIG_STEPS] : cy[TRIG_STEPS]);
  end

endmodule

FILE: sv/vaar_unit.sv
// Unit axis in Q30: sum of squares, pipelined integer square root and three
// pipelined restoring dividers. Uses vaar_pkg.
module vaar_unit import vaar_pkg::*; (
  input  logic  clk,
  input  comp_t axis_x,
  input  comp_t axis_y,
  input  comp_t axis_z,
  output q30_t  u_x,
  output q30_t  u_y,
  output q30_t  u_z
);

  comp_t a_in [3];
  assign a_in[0] = axis_x;
  assign a_in[1] = axis_y;
  assign a_in[2] = axis_z;

  // Squares, magnitudes and signs.
  logic [31:0] sq   [3];
  logic [15:0] amag [3];
  logic        asgn [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i]   <= 32'(33'(a_in[i]) * 33'(a_in[i]));
      amag[i] <= a_in[i][COMP_WIDTH-1] ? 16'(-17'(a_in[i])) : 16'(a_in[i]);
      asgn[i] <= a_in[i][COMP_WIDTH-1];
    end
  end

  // Square root of n * 2^28, one result bit per stage.
  logic [60:0] sr_n   [SQRT_STEPS+1];
  logic [60:0] sr_res [SQRT_STEPS+1];
  logic [15:0] sr_mag [SQRT_STEPS+1][3];
  logic        sr_sgn [SQRT_STEPS+1][3];

  always_ff @(posedge clk) begin
    sr_n[0]   <= (61'(sq[0]) + 61'(sq[1]) + 61'(sq[2])) << 28;
    sr_res[0] <= '0;
    sr_mag[0] <= amag;
    sr_sgn[0] <= asgn;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [60:0] BIT = 61'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [60:0] trial;
    assign trial = sr_res[j] + BIT;
    always_ff @(posedge clk) begin
      if (sr_n[j] >= trial) begin
        sr_n[j+1]   <= sr_n[j] - trial;
        sr_res[j+1] <= (sr_res[j] >> 1) + BIT;
      end else begin
        sr_n[j+1]   <= sr_n[j];
        sr_res[j+1] <= sr_res[j] >> 1;
      end
      sr_mag[j+1] <= sr_mag[j];
      sr_sgn[j+1] <= sr_sgn[j];
    end
  end

  logic [30:0] root;
  assign root = sr_res[SQRT_STEPS][30:0];

  // Rounded numerators |a| * 2^44 + q / 2, then one quotient bit per stage.
  logic [60:0] dv_r   [UDIV_STEPS+1][3];
  logic [30:0] dv_quo [UDIV_STEPS+1][3];
  logic [30:0] dv_d   [UDIV_STEPS+1];
  logic        dv_sgn [UDIV_STEPS+1][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_r[0][i]   <= (61'(sr_mag[SQRT_STEPS][i]) << 44) + 61'(root >> 1);
      dv_quo[0][i] <= '0;
    end
    dv_d[0]   <= root;
    dv_sgn[0] <= sr_sgn[SQRT_STEPS];
  end

  for (genvar k = 0; k < UDIV_STEPS; k++) begin : g_div
    logic [60:0] sub;
    assign sub = 61'(dv_d[k]) << (UDIV_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_r[k][i] >= sub) begin
          dv_r[k+1][i]   <= dv_r[k][i] - sub;
          dv_quo[k+1][i] <= dv_quo[k][i] | (31'(1) << (UDIV_STEPS - 1 - k));
        end else begin
          dv_r[k+1][i]   <= dv_r[k][i];
          dv_quo[k+1][i] <= dv_quo[k][i];
        end
      end
      dv_d[k+1]   <= dv_d[k];
      dv_sgn[k+1] <= dv_sgn[k];
    end
  end

  // Restore the signs.
  q30_t uq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq[i] = dv_sgn[UDIV_STEPS][i] ? -q30_t'(dv_quo[UDIV_STEPS][i])
                                     : q30_t'(dv_quo[UDIV_STEPS][i]);
    end
  end

  always_ff @(posedge clk) begin
    u_x <= uq[0];
    u_y <= uq[1];
    u_z <= uq[2];
  end

endmodule

FILE: sv/vaar_matrix.sv
// Rotation matrix from unit axis, cos and sin, and its product with the
// vector, over five register stages. Uses vaar_pkg.
module vaar_matrix import vaar_pkg::*; (
  input  logic  clk,
  input  q30_t  cos_q,
  input  q30_t  sin_q,
  input  q30_t  u_x,
  input  q30_t  u_y,
  input  q30_t  u_z,
  input  comp_t v_x,
  input  comp_t v_y,
  input  comp_t v_z,
  output comp_t r_x,
  output comp_t r_y,
  output comp_t r_z
);

  // Stage 1: axis products, sine terms and t = 1 - c.
  calc_t uu1 [6];
  calc_t su1 [3];
  calc_t t1, c1;
  comp_t v1 [3];
  always_ff @(posedge clk) begin
    uu1[0] <= mulq(calc_t'(u_x), calc_t'(u_x));
    uu1[1] <= mulq(calc_t'(u_x), calc_t'(u_y));
    uu1[2] <= mulq(calc_t'(u_x), calc_t'(u_z));
    uu1[3] <= mulq(calc_t'(u_y), calc_t'(u_y));
    uu1[4] <= mulq(calc_t'(u_y), calc_t'(u_z));
    uu1[5] <= mulq(calc_t'(u_z), calc_t'(u_z));
    su1[0] <= mulq(calc_t'(sin_q), calc_t'(u_x));
    su1[1] <= mulq(calc_t'(sin_q), calc_t'(u_y));
    su1[2] <= mulq(calc_t'(sin_q), calc_t'(u_z));
    t1     <= calc_t'(ONE_Q30) - calc_t'(cos_q);
    c1     <= calc_t'(cos_q);
    v1[0]  <= v_x;
    v1[1]  <= v_y;
    v1[2]  <= v_z;
  end

  // Stage 2: scale the axis products by t.
  calc_t tuu2 [6];
  calc_t su2  [3];
  calc_t c2;
  comp_t v2 [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      tuu2[i] <= mulq(t1, uu1[i]);
    end
    su2 <= su1;
    c2  <= c1;
    v2  <= v1;
  end

  // Stage 3: matrix entries, clamped to unit range.
  q30_t  m3 [9];
  comp_t v3 [3];
  always_ff @(posedge clk) begin
    m3[0] <= clamp_q30(tuu2[0] + c2);
    m3[1] <= clamp_q30(tuu2[1] + su2[2]);
    m3[2] <= clamp_q30(tuu2[2] - su2[1]);
    m3[3] <= clamp_q30(tuu2[1] - su2[2]);
    m3[4] <= clamp_q30(tuu2[3] + c2);
    m3[5] <= clamp_q30(tuu2[4] + su2[0]);
    m3[6] <= clamp_q30(tuu2[2] + su2[1]);
    m3[7] <= clamp_q30(tuu2[4] - su2[0]);
    m3[8] <= clamp_q30(tuu2[5] + c2);
    v3    <= v2;
  end

  // Stage 4: entry times component.
  logic signed [47:0] p4 [9];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p4[3*i+j] <= 48'(m3[3*i+j]) * 48'(v3[j]);
      end
    end
  end

  // Stage 5: row sums, rounding and saturation.
  logic signed [49:0] acc [3];
  logic signed [19:0] sh  [3];
  comp_t              sat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 50'(p4[3*i]) + 50'(p4[3*i+1]) + 50'(p4[3*i+2]) + 50'sd536870912;
      sh[i]  = 20'(acc[i] >>> 30);
      if (sh[i] > 20'sd32767) begin
        sat[i] = comp_t'(16'sh7fff);
      end else if (sh[i] < -20'sd32768) begin
        sat[i] = comp_t'(16'sh8000);
      end else begin
        sat[i] = sh[i][COMP_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    r_x <= sat[0];
    r_y <= sat[1];
    r_z <= sat[2];
  end

endmodule

FILE: sv/vector_axis_angle_rotate.sv
// Top level of the axis-angle rotation block: trig, axis and matrix units
// with the delay lines that keep words aligned. Uses vaar_pkg.
//
//   port group         direction  handshake
//   start/angle/vec/axis  in      taken when start is high and busy is low
//   done/out/degenerate   out     one cycle per word, strobed by done
//
// A word can enter every cycle outside reset.
// The latency is set by the axis path: a 30-stage square root and a
// 31-stage divider, then five matrix stages and the output register.
// busy is high only during reset; reset empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module vector_axis_angle_rotate import vaar_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] angle_deg,
  input  comp_t                         vec_x,
  input  comp_t                         vec_y,
  input  comp_t                         vec_z,
  input  comp_t                         axis_x,
  input  comp_t                         axis_y,
  input  comp_t                         axis_z,
  output logic                          done,
  output comp_t                         out_x,
  output comp_t                         out_y,
  output comp_t                         out_z,
  output logic                          degenerate
);

  typedef struct packed {
    logic  zero_ang;
    logic  degen;
    comp_t vx;
    comp_t vy;
    comp_t vz;
  } side_t;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Special cases are decided at the input and ride along.
  side_t side_in;
  always_comb begin
    side_in.zero_ang = (angle_deg == '0);
    side_in.degen    = (vec_x == '0 && vec_y == '0 && vec_z == '0) ||
                       (axis_x == '0 && axis_y == '0 && axis_z == '0);
    side_in.vx       = vec_x;
    side_in.vy       = vec_y;
    side_in.vz       = vec_z;
  end

  q30_t cos_q, sin_q, u_x, u_y, u_z;

  vaar_trig u_trig (
    .clk   (clk),
    .angle (angle_deg),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  vaar_unit u_unit (
    .clk    (clk),
    .axis_x (axis_x),
    .axis_y (axis_y),
    .axis_z (axis_z),
    .u_x    (u_x),
    .u_y    (u_y),
    .u_z    (u_z)
  );

  // Delay cos and sin to line up with the unit axis.
  q30_t cos_d [TRIG_PAD];
  q30_t sin_d [TRIG_PAD];
  always_ff @(posedge clk) begin
    cos_d[0] <= cos_q;
    sin_d[0] <= sin_q;
    for (int k = 1; k < TRIG_PAD; k++) begin
      cos_d[k] <= cos_d[k-1];
      sin_d[k] <= sin_d[k-1];
    end
  end

  // Side data and valid bits across the axis path.
  side_t              side_a [UNIT_LAT];
  logic [UNIT_LAT-1:0] valid_a;
  always_ff @(posedge clk) begin
    side_a[0] <= side_in;
    for (int k = 1; k < UNIT_LAT; k++) begin
      side_a[k] <= side_a[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= '0;
    end else begin
      valid_a <= {valid_a[UNIT_LAT-2:0], accept};
    end
  end

  comp_t r_x, r_y, r_z;

  vaar_matrix u_matrix (
    .clk   (clk),
    .cos_q (cos_d[TRIG_PAD-1]),
    .sin_q (sin_d[TRIG_PAD-1]),
    .u_x   (u_x),
    .u_y   (u_y),
    .u_z   (u_z),
    .v_x   (side_a[UNIT_LAT-1].vx),
    .v_y   (side_a[UNIT_LAT-1].vy),
    .v_z   (side_a[UNIT_LAT-1].vz),
    .r_x   (r_x),
    .r_y   (r_y),
    .r_z   (r_z)
  );

  // Side data and valid bits across the matrix stages.
  side_t              side_b [MAT_LAT];
  logic [MAT_LAT-1:0] valid_b;
  always_ff @(posedge clk) begin
    side_b[0] <= side_a[UNIT_LAT-1];
    for (int k = 1; k < MAT_LAT; k++) begin
      side_b[k] <= side_b[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= '0;
    end else begin
      valid_b <= {valid_b[MAT_LAT-2:0], valid_a[UNIT_LAT-1]};
    end
  end

  // Output word: pass-through, degenerate zeros, or the rotated vector.
  side_t fin;
  assign fin = side_b[MAT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_b[MAT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fin.zero_ang) begin
      out_x      <= fin.vx;
      out_y      <= fin.vy;
      out_z      <= fin.vz;
      degenerate <= 1'b0;
    end else if (fin.degen) begin
      out_x      <= '0;
      out_y      <= '0;
      out_z      <= '0;
      degenerate <= 1'b1;
    end else begin
      out_x      <= r_x;
      out_y      <= r_y;
      out_z      <= r_z;
      degenerate <= 1'b0;
    end
  end

endmodule

FILE: sv/vaar_checker.sv
// Port-level checker for the axis-angle rotation block and its bind.
// Uses vaar_pkg and the assertion macros of the defines header.
`include "vector_axis_angle_rotate_defines.svh"

module vaar_checker import vaar_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [ANGLE_WIDTH-1:0] angle_deg,
  input comp_t                         vec_x,
  input comp_t                         vec_y,
  input comp_t                         vec_z,
  input comp_t                         axis_x,
  input comp_t                         axis_y,
  input comp_t                         axis_z,
  input logic                          done,
  input comp_t                         out_x,
  input comp_t                         out_y,
  input comp_t                         out_z,
  input logic                          degenerate
);

  // Reset empties the pipeline.
  `VAAR_ASSERT_NEXT(a_reset_clears, clk, rst, !done)

  // Every accepted word gives a result after the fixed latency.
  `VAAR_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##TOTAL_LAT done)

  // No result appears without a word accepted the latency before.
  `VAAR_ASSERT_IMPL(a_no_extra, clk, rst, done, $past(start && !busy, TOTAL_LAT))

  // A degenerate word shows all-zero components.
  `VAAR_ASSERT_IMPL(a_degen_zero, clk, rst, done && degenerate,
                    (out_x == '0 && out_y == '0 && out_z == '0))

endmodule

bind vector_axis_angle_rotate vaar_checker u_vaar_checker (.*);

FILE: test/vector_axis_angle_rotate_test.sv
// Self-checking testbench of the axis-angle rotation block: directed table, then random words.
// Depends on vaar_pkg and vector_axis_angle_rotate; an internal predictor computes each result.
module vector_axis_angle_rotate_test;
  import vaar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] ang;
    comp_t vx, vy, vz, ax, ay, az;
    logic known;
    comp_t ex, ey, ez;
    logic edeg;
  } stim_row_t;

  typedef struct {
    comp_t x, y, z;
    logic deg;
  } rotation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ANGLE_WIDTH-1:0] angle_deg = '0;
  comp_t vec_x = '0, vec_y = '0, vec_z = '0;
  comp_t axis_x = '0, axis_y = '0, axis_z = '0;
  logic done;
  comp_t out_x, out_y, out_z;
  logic degenerate;

  rotation_t rotated_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1400;

  vector_axis_angle_rotate u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .angle_deg(angle_deg), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .degenerate(degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Floor shift, rounding helpers and integer square root of the predictor.
  function automatic longint floor_shift(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint round_away_div(input longint num, input longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return floor_shift(a * b + (64'sd1 << 29), 30);
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // CORDIC cos and sin of an angle in 1/64-degree units, both in Q30.
  function automatic void cos_sin(input longint ang, output longint c, output longint s);
    longint r, x, y, z, xs, ys;
    bit flip;
    r = ang % FULL_TURN;
    flip = 0;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r < -HALF_TURN) r += FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1;
    end
    if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1;
    end
    z = round_away_div(r * 64'sd3373259426, HALF_TURN);
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(atan_q30(i));
      end else begin
        x += ys;
        y -= xs;
        z += longint'(atan_q30(i));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -ONE_Q30, ONE_Q30);
    s = clip(y, -ONE_Q30, ONE_Q30);
  endfunction

  // Rotation of one word about its axis.
  function automatic rotation_t rotate_word(input stim_row_t w);
    rotation_t res;
    longint v[3], a[3], u[3], m[3][3];
    longint c, s, t, big, acc, mag;
    longint unsigned n, q;
    v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
    a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
    res.deg = 1'b0;
    if (w.ang == 0) begin
      res.x = w.vx; res.y = w.vy; res.z = w.vz;
      return res;
    end
    if ((v[0] == 0 && v[1] == 0 && v[2] == 0) || (a[0] == 0 && a[1] == 0 && a[2] == 0)) begin
      res.x = '0; res.y = '0; res.z = '0; res.deg = 1'b1;
      return res;
    end
    // Scale the axis down until it fits in 16 bits of magnitude.
    forever begin
      big = 0;
      for (int i = 0; i < 3; i++) begin
        mag = (a[i] < 0) ? -a[i] : a[i];
        if (mag > big) big = mag;
      end
      if (big < (64'sd1 << 16)) break;
      for (int i = 0; i < 3; i++) a[i] = floor_shift(a[i], 1);
    end
    n = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    q = int_sqrt(n << 28);
    for (int i = 0; i < 3; i++) u[i] = round_away_div(a[i] * (64'sd1 << 44), longint'(q));
    cos_sin(w.ang, c, s);
    t = ONE_Q30 - c;
    m[0][0] = q30_product(t, q30_product(u[0], u[0])) + c;
    m[0][1] = q30_product(t, q30_product(u[0], u[1])) + q30_product(s, u[2]);
    m[0][2] = q30_product(t, q30_product(u[0], u[2])) - q30_product(s, u[1]);
    m[1][0] = q30_product(t, q30_product(u[0], u[1])) - q30_product(s, u[2]);
    m[1][1] = q30_product(t, q30_product(u[1], u[1])) + c;
    m[1][2] = q30_product(t, q30_product(u[1], u[2])) + q30_product(s, u[0]);
    m[2][0] = q30_product(t, q30_product(u[0], u[2])) + q30_product(s, u[1]);
    m[2][1] = q30_product(t, q30_product(u[1], u[2])) - q30_product(s, u[0]);
    m[2][2] = q30_product(t, q30_product(u[2], u[2])) + c;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += clip(m[i][j], -ONE_Q30, ONE_Q30) * v[j];
      acc = clip(floor_shift(acc + (64'sd1 << 29), 30), -32768, 32767);
      if (i == 0) res.x = comp_t'(acc);
      else if (i == 1) res.y = comp_t'(acc);
      else res.z = comp_t'(acc);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Drive one word at the falling edge and hold it until accepted.
  task automatic send_word(input stim_row_t w);
    rotation_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    angle_deg <= w.ang;
    vec_x <= w.vx; vec_y <= w.vy; vec_z <= w.vz;
    axis_x <= w.ax; axis_y <= w.ay; axis_z <= w.az;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = rotate_word(w);
    if (w.known && (p.x !== w.ex || p.y !== w.ey || p.z !== w.ez || p.deg !== w.edeg))
      report_mismatch("table row vs predictor", p.x, w.ex);
    rotated_q.push_back(p);
    @(negedge clk);
  endtask

  function automatic stim_row_t row(input int ang, input int vx, input int vy, input int vz,
                                    input int ax, input int ay, input int az,
                                    input bit known = 0, input int ex = 0, input int ey = 0,
                                    input int ez = 0, input bit edeg = 0);
    stim_row_t r;
    r.ang = ang[15:0];
    r.vx = vx[15:0]; r.vy = vy[15:0]; r.vz = vz[15:0];
    r.ax = ax[15:0]; r.ay = ay[15:0]; r.az = az[15:0];
    r.known = known;
    r.ex = ex[15:0]; r.ey = ey[15:0]; r.ez = ez[15:0];
    r.edeg = edeg;
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(5))
      0: return comp_t'($urandom_range(1) ? 16'h7fff : 16'h8000);
      1: return comp_t'($urandom_range(512) - 256);
      2: return '0;
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    rotation_t want;
    if (!rst && done) begin
      idle_cycles <= 0;
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected word", out_x, 0);
      end else begin
        want = rotated_q.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (degenerate !== want.deg) report_mismatch("degenerate", degenerate, want.deg);
      end
    end else if (!rst && start && !busy) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no accepted word in either direction.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t w;
    int drain;
    // Directed rows: zero angle, degenerate inputs, extremes, quarter turns.
    table_rows.push_back(row(0, 100, -200, 300, 0, 0, 0, 1, 100, -200, 300, 0));
    table_rows.push_back(row(0, 32767, -32768, 0, 256, 0, 0, 1, 32767, -32768, 0, 0));
    table_rows.push_back(row(5760, 0, 0, 0, 0, 0, 256, 1, 0, 0, 0, 1));
    table_rows.push_back(row(5760, 256, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(row(-23040, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(row(5760, 256, 0, 0, 0, 0, 256));
    table_rows.push_back(row(-5760, 256, 0, 0, 0, 0, 256));
    table_rows.push_back(row(11520, 256, 512, 0, 0, 0, 256));
    table_rows.push_back(row(23040, 256, 512, 768, 256, 256, 256));
    table_rows.push_back(row(-23040, 256, 512, 768, 1, 0, 0));
    table_rows.push_back(row(32767, 1000, -1000, 50, 0, 256, 0));
    table_rows.push_back(row(-32768, 1000, -1000, 50, 256, 0, 0));
    table_rows.push_back(row(1, 32767, 32767, 32767, 32767, -32768, 32767));
    table_rows.push_back(row(-1, -32768, -32768, -32768, -32768, -32768, -32768));
    table_rows.push_back(row(2880, 32767, 32767, 32767, 0, 0, 1));
    table_rows.push_back(row(5761, -32768, 32767, 0, 0, 1, 0));
    table_rows.push_back(row(11519, 1, 1, 1, 1, 1, 1));
    table_rows.push_back(row(-11520, 32767, 0, 0, 0, 32767, 0));
    table_rows.push_back(row(17280, 100, 200, 300, -1, -1, -1));
    table_rows.push_back(row(7777, -1, 0, 0, 12345, -6789, 255));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    foreach (table_rows[i]) send_word(table_rows[i]);

    // Random words in three idling phases.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 3) send_idle_pct = 66;
      if (k == 2 * RANDOM_WORDS / 3) send_idle_pct = 0;
      case ($urandom_range(3))
        0: w.ang = 16'($urandom_range(46080) - 23040);
        1: w.ang = 16'($urandom);
        2: w.ang = 16'($urandom_range(40) - 20 + 5760 * $urandom_range(4) - 11520);
        default: w.ang = ($urandom_range(15) == 0) ? '0 : 16'($urandom_range(2000) - 1000);
      endcase
      w.vx = rand_comp(); w.vy = rand_comp(); w.vz = rand_comp();
      w.ax = rand_comp(); w.ay = rand_comp(); w.az = rand_comp();
      w.known = 0;
      send_word(w);
    end
    start <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < TOTAL_LAT + 8) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
